[rtl/cfs_pkg.sv]
// Shared types, constants and the code table of the charger flag status block.
`timescale 1ns / 1ps

package cfs_pkg;

   localparam int ElapsedWidth = 16;
   localparam int FreqWidth    = 8;
   localparam int StatusWidth  = 4;
   localparam int NumerWidth   = 10;
   localparam int DivSteps     = NumerWidth;
   localparam int StepCntWidth = $clog2(DivSteps);
   localparam int CodeCount    = 7;

   localparam logic [ElapsedWidth-1:0] ElapsedMax   = '1;
   localparam logic [ElapsedWidth-1:0] SilentReset  = 16'(250 * 10);
   localparam logic [NumerWidth-1:0]   FreqNumer    = 10'd1000;
   localparam logic [FreqWidth-1:0]    FreqMax      = '1;

   typedef enum logic [StatusWidth-1:0] {
      STATUS_NO_INPUT    = 4'd0,
      STATUS_VALID_INPUT = 4'd1,
      STATUS_END_CHARGE  = 4'd2,
      STATUS_CHARGING    = 4'd3,
      STATUS_OVERCHARGE  = 4'd4,
      STATUS_TIMEOUT     = 4'd5,
      STATUS_LOW_BATT    = 4'd6,
      STATUS_THERMAL     = 4'd7,
      STATUS_TEMP_FAULT  = 4'd8,
      STATUS_UNKNOWN     = 4'd9
   } cfs_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } cfs_state_type;

   // divider handshake back to the controller
   typedef struct packed {
      logic                  done;
      logic [NumerWidth-1:0] quotient;
   } cfs_div_result_type;

   localparam logic [FreqWidth-1:0] CodeFreq [CodeCount] = '{
      8'd4, 8'd6, 8'd8, 8'd10, 8'd12, 8'd14, 8'd16
   };

   function automatic cfs_status_type status_of_freq(input logic [FreqWidth-1:0] freq);
      cfs_status_type res;
      res = STATUS_UNKNOWN;
      for (int i = 0; i < CodeCount; i++) begin
         if (freq == CodeFreq[i]) begin
            res = cfs_status_type'(StatusWidth'(int'(STATUS_END_CHARGE) + i));
         end
      end
      return res;
   endfunction

endpackage

[rtl/cfs_channels.sv]
// Channel interfaces: flag sample requests, status responses, config writes.
`timescale 1ns / 1ps

interface cfs_req_if;
   logic valid;
   logic ready;
   logic flag_level;
   modport source (output valid, output flag_level, input ready);
   modport sink   (input valid, input flag_level, output ready);
endinterface

interface cfs_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [cfs_pkg::StatusWidth-1:0] status;
   logic [cfs_pkg::FreqWidth-1:0]   measured_freq;
   modport source (output valid, output status, output measured_freq, input ready);
   modport sink   (input valid, input status, input measured_freq, output ready);
endinterface

interface cfs_csr_if;
   logic                            valid;
   logic                            ready;
   logic [cfs_pkg::ElapsedWidth-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[rtl/cfs_divider.sv]
// Bit-serial restoring divider: 1000 / divisor, one quotient bit per cycle.
`timescale 1ns / 1ps

module cfs_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [cfs_pkg::ElapsedWidth-1:0]  divisor,
   output cfs_pkg::cfs_div_result_type       result
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [cfs_pkg::StepCntWidth-1:0]   count_ff, count_in;
   logic [cfs_pkg::NumerWidth-1:0]     numer_ff, numer_in;
   logic [cfs_pkg::NumerWidth-1:0]     rem_ff, rem_in;
   logic [cfs_pkg::NumerWidth-1:0]     quot_ff, quot_in;
   logic [cfs_pkg::ElapsedWidth-1:0]   divisor_ff, divisor_in;

   logic [cfs_pkg::NumerWidth:0]       trial;
   logic                               fits;

   always_comb begin
      trial = {rem_ff, numer_ff[cfs_pkg::NumerWidth-1]};
      fits  = cfs_pkg::ElapsedWidth'(trial) >= divisor_ff;

      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      numer_in   = numer_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      divisor_in = divisor_ff;

      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         numer_in   = cfs_pkg::FreqNumer;
         rem_in     = '0;
         quot_in    = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         numer_in = {numer_ff[cfs_pkg::NumerWidth-2:0], 1'b0};
         quot_in  = {quot_ff[cfs_pkg::NumerWidth-2:0], fits};
         // partial remainder never exceeds the numerator prefix
         rem_in   = fits ? cfs_pkg::NumerWidth'(trial - divisor_ff[cfs_pkg::NumerWidth:0])
                         : cfs_pkg::NumerWidth'(trial);
         count_in = count_ff + 1'b1;
         if (count_ff == cfs_pkg::StepCntWidth'(cfs_pkg::DivSteps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      numer_ff   <= numer_in;
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_in;
   end

   assign result.done     = done_ff;
   assign result.quotient = quot_ff;

`ifndef NO_ASSERTIONS
   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff || $past(start))
      else $error("divider done while still iterating");
   a_start_sets_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && !done_ff)
      else $error("divider did not begin after start");
   a_busy_not_start: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start |=> count_ff == $past(count_ff) + 1'b1 || !busy_ff)
      else $error("divider step count skipped");
`endif

endmodule

[rtl/charger_flag_frequency_status_core.sv]
// Top level: charger flag frequency measurement and status decode.
`timescale 1ns / 1ps
//
//  channel  dir  handshake     payload
//  req_if   in   valid/ready   flag_level (1)
//  rsp_if   out  valid/ready   status (4), measured_freq (8)
//  csr_if   in   valid/ready   data (16) -> max_silent_period
//
//  A request without a rising flag edge passes the accept and emit states.
//  A rising edge adds the bit-serial divider and its done register between
//  them; a new request is accepted only in the idle state.
//  Synchronous reset clears flag history, elapsed count, frequency and sets
//  max_silent_period to 2500. A stalled response holds in its register; the
//  next request is accepted meanwhile and waits in the emit state for the slot.

module charger_flag_frequency_status_core (
   input  logic          clock,
   input  logic          reset,
   cfs_req_if.sink       req_if,
   cfs_rsp_if.source     rsp_if,
   cfs_csr_if.sink       csr_if
);

   cfs_pkg::cfs_state_type               state_ff, state_in;
   logic                                 prev_ff, prev_in;
   logic                                 level_ff, level_in;
   logic [cfs_pkg::ElapsedWidth-1:0]     elapsed_ff, elapsed_in;
   logic [cfs_pkg::FreqWidth-1:0]        freq_ff, freq_in;
   logic [cfs_pkg::ElapsedWidth-1:0]     max_ff, max_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [cfs_pkg::StatusWidth-1:0]      rsp_status_ff, rsp_status_in;
   logic [cfs_pkg::FreqWidth-1:0]        rsp_freq_ff, rsp_freq_in;

   logic                                 accept;
   logic                                 rise;
   logic                                 slot_free;
   logic                                 div_start;
   logic [cfs_pkg::ElapsedWidth-1:0]     elapsed_inc;
   cfs_pkg::cfs_status_type              status_now;
   cfs_pkg::cfs_div_result_type          div_res;

   cfs_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .divisor (elapsed_inc),
      .result  (div_res)
   );

   assign req_if.ready = (state_ff == cfs_pkg::ST_IDLE);
   assign csr_if.ready = 1'b1;
   assign accept       = req_if.valid && req_if.ready;
   assign rise         = !prev_ff && req_if.flag_level;
   assign slot_free    = !rsp_valid_ff || rsp_if.ready;
   assign div_start    = accept && rise;
   assign elapsed_inc  = (elapsed_ff == cfs_pkg::ElapsedMax) ? elapsed_ff
                                                             : elapsed_ff + 1'b1;

   always_comb begin
      if (elapsed_ff > max_ff) begin
         status_now = level_ff ? cfs_pkg::STATUS_NO_INPUT : cfs_pkg::STATUS_VALID_INPUT;
      end else begin
         status_now = cfs_pkg::status_of_freq(freq_ff);
      end
   end

   always_comb begin
      state_in      = state_ff;
      prev_in       = prev_ff;
      level_in      = level_ff;
      elapsed_in    = elapsed_ff;
      freq_in       = freq_ff;
      max_in        = max_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_freq_in   = rsp_freq_ff;

      if (csr_if.valid) begin
         max_in = csr_if.data;
      end

      case (state_ff)
         cfs_pkg::ST_IDLE: begin
            if (accept) begin
               prev_in  = req_if.flag_level;
               level_in = req_if.flag_level;
               if (rise) begin
                  elapsed_in = '0;
                  state_in   = cfs_pkg::ST_DIVIDE;
               end else begin
                  elapsed_in = elapsed_inc;
                  state_in   = cfs_pkg::ST_EMIT;
               end
            end
         end
         cfs_pkg::ST_DIVIDE: begin
            if (div_res.done) begin
               // quotients above 255 only come from periods under 4 ms
               freq_in  = (div_res.quotient[cfs_pkg::NumerWidth-1:cfs_pkg::FreqWidth] != '0)
                        ? cfs_pkg::FreqMax : div_res.quotient[cfs_pkg::FreqWidth-1:0];
               state_in = cfs_pkg::ST_EMIT;
            end
         end
         cfs_pkg::ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_now;
               rsp_freq_in   = freq_ff;
               state_in      = cfs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cfs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cfs_pkg::ST_IDLE;
         prev_ff      <= 1'b0;
         level_ff     <= 1'b0;
         elapsed_ff   <= '0;
         freq_ff      <= '0;
         max_ff       <= cfs_pkg::SilentReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         level_ff     <= level_in;
         elapsed_ff   <= elapsed_in;
         freq_ff      <= freq_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_freq_ff   <= rsp_freq_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.status        = rsp_status_ff;
   assign rsp_if.measured_freq = rsp_freq_ff;

`ifndef NO_ASSERTIONS
   a_rise_divides: assert property (@(posedge clock) disable iff (reset)
      accept && rise |=> state_ff == cfs_pkg::ST_DIVIDE && elapsed_ff == '0)
      else $error("rising edge did not start a frequency measurement");
   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> state_ff == cfs_pkg::ST_DIVIDE)
      else $error("divider result outside divide state");
   a_freq_only_from_div: assert property (@(posedge clock) disable iff (reset)
      !div_res.done |=> $stable(freq_ff))
      else $error("frequency changed without a divider result");
   a_elapsed_grows: assert property (@(posedge clock) disable iff (reset)
      accept && !rise |=> elapsed_ff >= $past(elapsed_ff))
      else $error("elapsed count dropped without an edge");
`endif

endmodule

[bench/charger_flag_frequency_status_core_test.sv]
// Self-checking bench for the charger flag frequency status core.
`timescale 1ns / 1ps

module charger_flag_frequency_status_core_test;

   localparam int StallLimit = 5000;
   localparam int PhaseSamples = 100;
   localparam int NoCap = 1 << 30;

   typedef struct {
      cfs_pkg::cfs_status_type       status;
      logic [cfs_pkg::FreqWidth-1:0] freq;
   } status_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cfs_req_if req_if();
   cfs_rsp_if rsp_if();
   cfs_csr_if csr_if();

   logic                             req_valid_q = 1'b0;
   logic                             req_flag_q  = 1'b0;
   logic                             rsp_ready_q = 1'b0;
   logic                             csr_valid_q = 1'b0;
   logic [cfs_pkg::ElapsedWidth-1:0] csr_data_q  = '0;

   assign req_if.valid      = req_valid_q;
   assign req_if.flag_level = req_flag_q;
   assign rsp_if.ready      = rsp_ready_q;
   assign csr_if.valid      = csr_valid_q;
   assign csr_if.data       = csr_data_q;

   charger_flag_frequency_status_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state, matches the block after reset
   logic                             last_level    = 1'b0;
   logic [cfs_pkg::ElapsedWidth-1:0] ms_since_rise = '0;
   logic [cfs_pkg::FreqWidth-1:0]    flag_freq     = '0;
   logic [cfs_pkg::ElapsedWidth-1:0] silent_limit  = cfs_pkg::SilentReset;

   logic            pending_flags[$];
   status_word_type expected_status[$];

   logic req_taken    = 1'b0;
   logic quiet_mode   = 1'b0;
   int   send_gap     = 0;
   int   stall_left   = 0;
   int   hold_left    = 0;
   int   hold_request = 0;
   int   calm_left    = 0;
   int   stuck_cycles = 0;
   int   queue_cap    = NoCap;

   int error_count       = 0;
   int samples_queued    = 0;
   int samples_sent      = 0;
   int responses_checked = 0;
   int csr_writes        = 0;

   int unsigned code_period_lo[cfs_pkg::CodeCount] = '{201, 143, 112, 91, 77, 67, 59};
   int unsigned code_period_hi[cfs_pkg::CodeCount] = '{250, 166, 125, 100, 83, 71, 62};

   function automatic status_word_type predict_status(input logic level);
      status_word_type word;
      int unsigned     quotient;
      if (ms_since_rise != cfs_pkg::ElapsedMax) ms_since_rise = ms_since_rise + 1'b1;
      if (!last_level && level) begin
         quotient      = 1000 / int'(ms_since_rise);
         flag_freq     = (quotient > 255) ? cfs_pkg::FreqMax : cfs_pkg::FreqWidth'(quotient);
         ms_since_rise = '0;
      end
      last_level = level;
      word.freq  = flag_freq;
      if (ms_since_rise > silent_limit) begin
         word.status = level ? cfs_pkg::STATUS_NO_INPUT : cfs_pkg::STATUS_VALID_INPUT;
      end else begin
         case (flag_freq)
            8'd4:    word.status = cfs_pkg::STATUS_END_CHARGE;
            8'd6:    word.status = cfs_pkg::STATUS_CHARGING;
            8'd8:    word.status = cfs_pkg::STATUS_OVERCHARGE;
            8'd10:   word.status = cfs_pkg::STATUS_TIMEOUT;
            8'd12:   word.status = cfs_pkg::STATUS_LOW_BATT;
            8'd14:   word.status = cfs_pkg::STATUS_THERMAL;
            8'd16:   word.status = cfs_pkg::STATUS_TEMP_FAULT;
            default: word.status = cfs_pkg::STATUS_UNKNOWN;
         endcase
      end
      return word;
   endfunction

   // request driver
   always @(negedge clock) begin
      logic next_valid;
      logic next_flag;
      next_valid = req_valid_q;
      next_flag  = req_flag_q;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_valid_q && req_taken) next_valid = 1'b0;
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_flags.size() > 0) begin
               next_flag  = pending_flags.pop_front();
               next_valid = 1'b1;
               if (!quiet_mode && calm_left == 0 && $urandom_range(0, 5) == 0)
                  send_gap = $urandom_range(1, 14);
            end
         end
      end
      req_valid_q <= next_valid;
      req_flag_q  <= next_flag;
   end

   // response receiver with random stalls and a requested long hold-off
   always @(negedge clock) begin
      logic next_ready;
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (reset) begin
         next_ready = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         next_ready = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         next_ready = 1'b0;
      end else if (!quiet_mode && calm_left == 0 && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 14) - 1;
         next_ready = 1'b0;
      end else begin
         next_ready = 1'b1;
      end
      rsp_ready_q <= next_ready;
   end

   // acceptance, prediction and response check
   always @(posedge clock) begin
      status_word_type exp_word;
      req_taken = !reset && req_if.valid && req_if.ready;
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 199) == 0) calm_left = $urandom_range(40, 300);
      if (!reset) begin
         if (csr_if.valid && csr_if.ready) begin
            silent_limit = csr_if.data;
            csr_writes++;
         end
         if (req_taken) begin
            expected_status.push_back(predict_status(req_if.flag_level));
            samples_sent++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_status.size() == 0) begin
               $error("response with no request outstanding: status %0d, measured_freq %0d",
                      rsp_if.status, rsp_if.measured_freq);
               error_count++;
            end else begin
               exp_word = expected_status.pop_front();
               if (rsp_if.status !== exp_word.status) begin
                  $error("status: expected %0d, actual %0d", exp_word.status, rsp_if.status);
                  error_count++;
               end
               if (rsp_if.measured_freq !== exp_word.freq) begin
                  $error("measured_freq: expected %0d, actual %0d",
                         exp_word.freq, rsp_if.measured_freq);
                  error_count++;
               end
               responses_checked++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= StallLimit) begin
            $display("Timeout: no handshake for %0d cycles", StallLimit);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // samples beyond the current phase budget are dropped
   task automatic push_flag(input logic level);
      if (samples_queued >= queue_cap) return;
      pending_flags.push_back(level);
      samples_queued++;
   endtask

   task automatic push_level(input logic level, input int count);
      for (int i = 0; i < count; i++) push_flag(level);
   endtask

   // rising edges every period samples, high for high_len of them
   task automatic push_wave(input int period, input int high_len, input int count);
      for (int i = 0; i < count; i++) begin
         push_level(1'b1, high_len);
         push_level(1'b0, period - high_len);
      end
   endtask

   task automatic push_random_segment();
      int kind;
      int code;
      int period;
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
         code   = $urandom_range(0, cfs_pkg::CodeCount - 1);
         period = $urandom_range(code_period_lo[code], code_period_hi[code]);
         // now and then just outside the window
         if ($urandom_range(0, 5) == 0) period = code_period_lo[code] - 1;
         else if ($urandom_range(0, 5) == 0) period = code_period_hi[code] + 1;
         push_wave(period, $urandom_range(1, period - 1), 1);
      end else if (kind == 6) begin
         period = $urandom_range(2, 40);
         push_wave(period, $urandom_range(1, period - 1), $urandom_range(1, 6));
      end else if (kind == 7) begin
         for (int i = $urandom_range(1, 40); i > 0; i--) push_flag(1'($urandom_range(0, 1)));
      end else if (kind == 8) begin
         push_level(1'($urandom_range(0, 1)), $urandom_range(1, 100));
      end else begin
         period = $urandom_range(2, 300);
         push_wave(period, $urandom_range(1, period - 1), 1);
      end
   endtask

   task automatic push_random_phase(input int budget);
      queue_cap = samples_queued + budget;
      while (samples_queued < queue_cap) push_random_segment();
      queue_cap = NoCap;
   endtask

   task automatic wait_drained();
      while (pending_flags.size() != 0 || req_valid_q || expected_status.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_silent_period(input logic [cfs_pkg::ElapsedWidth-1:0] value);
      wait_drained();
      repeat (16) @(posedge clock);
      @(negedge clock);
      csr_data_q  <= value;
      csr_valid_q <= 1'b1;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_valid_q <= 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // high first sample is an edge; edges 1..3 ms apart saturate the frequency
      push_flag(1'b1);
      push_flag(1'b0);
      push_flag(1'b1);
      push_level(1'b0, 2);
      push_flag(1'b1);
      push_level(1'b0, 3);
      push_flag(1'b1);
      push_flag(1'b1);
      push_wave(62, 30, 2);

      // silent low, edge after the gap, then silent high
      write_silent_period(16'd40);
      push_level(1'b0, 50);
      push_flag(1'b1);
      push_level(1'b1, 50);

      write_silent_period(16'd1);
      push_random_phase(PhaseSamples);

      write_silent_period(16'd100);
      push_random_phase(PhaseSamples);
      hold_request = 400;

      write_silent_period(16'($urandom_range(1, 3000)));
      push_random_phase(PhaseSamples / 2);
      wait_drained();
      push_random_phase(PhaseSamples / 2);

      write_silent_period(16'd300);
      push_random_phase(PhaseSamples);

      write_silent_period(16'd65534);
      quiet_mode = 1'b1;
      push_random_phase(PhaseSamples);

      wait_drained();
      repeat (32) @(posedge clock);
      $display("Run covered %0d flag samples and %0d checked responses", samples_sent,
               responses_checked);
      $display("across %0d silent-period writes and a long receiver hold-off", csr_writes);
      if (error_count == 0 && expected_status.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
